// File: design/pcs_pkg.sv
// Shared types, constants and elaboration-time functions of the pose confidence block.
package pcs_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_PX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA_GOOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA_BAD  = 2'd2;

  localparam logic [15:0] SIGMA_RST      = 16'd512;
  localparam logic [31:0] KAPPA_GOOD_RST = 32'd25600;
  localparam logic [31:0] KAPPA_BAD_RST  = 32'd2560000;
  localparam logic [31:0] COND_DEFAULT   = 32'd256000;

  localparam int W_R = 26214;
  localparam int W_C = 16384;
  localparam int W_I = 13107;
  localparam int W_M = 9830;
  localparam int HALF_LOG2E_Q16 = 47274;

  localparam int LOG_FRAC_BITS = 16;
  localparam int LOG_Q         = 30;
  localparam int LOG_MANT_W    = 31;
  localparam int LOG1_VW       = 36;
  localparam int LOG2_VW       = 22;
  localparam int LV_W          = 23;
  localparam int DIV_NW        = 48;
  localparam int DIV_DW        = 32;
  localparam int EXP_BITS      = 16;
  localparam int SUM_W         = 50;

  localparam logic [15:0] CONF_ONE = 16'd32768;

  typedef struct packed {
    logic e_nz;
    logic zero;
    logic c_active;
    logic m_use;
  } pcs_fa_t;

  typedef struct packed {
    logic signed [LV_W-1:0] li;
    logic signed [LV_W-1:0] lm;
    logic                   zero;
    logic                   e_nz;
    logic                   c_active;
  } pcs_fb_t;

  typedef struct packed {
    logic signed [LV_W-1:0] lc;
    logic signed [LV_W-1:0] li;
    logic signed [LV_W-1:0] lm;
    logic                   zero;
    logic                   e_nz;
  } pcs_fc_t;

  typedef struct packed {
    logic       zero;
    logic       sat;
    logic       big;
    logic       gfull;
    logic [4:0] n;
  } pcs_fg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [30:0] exp_root(input int j);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 0; i <= j; i++) begin
      r = isqrt64(r << LOG_Q);
    end
    return r[30:0];
  endfunction

endpackage

// File: design/pcs_in_if.sv
// Input channel carrying one pose-fit report item.
interface pcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] reproj_error;
  logic [31:0] cond_number;
  logic [7:0]  inlier_count;
  logic [7:0]  point_count;
  logic [31:0] cost_prior;
  logic [31:0] cost_final;

  modport source (
    output valid, reproj_error, cond_number, inlier_count, point_count,
           cost_prior, cost_final,
    input  ready
  );
  modport sink (
    input  valid, reproj_error, cond_number, inlier_count, point_count,
           cost_prior, cost_final,
    output ready
  );
endinterface

// File: design/pcs_out_if.sv
// Result channel carrying one confidence item.
interface pcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] confidence;

  modport source (output valid, confidence, input ready);
  modport sink (input valid, confidence, output ready);
endinterface

// File: design/pcs_cfg_if.sv
// Configuration write channel: register index and write data.
interface pcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/pcs_delay.sv
// Enabled shift-register delay line for side data of the pipeline.
module pcs_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  generate
    if (D == 0) begin : g_none
      assign q = d;
    end else begin : g_sh
      logic [W-1:0] sh_r [D];
      always_ff @(posedge clk) begin
        if (en) begin
          sh_r[0] <= d;
          for (int i = 1; i < D; i++) begin
            sh_r[i] <= sh_r[i-1];
          end
        end
      end
      assign q = sh_r[D-1];
    end
  endgenerate
endmodule

// File: design/pcs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pcs_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  logic [DW-1:0] rem_r [NW-1];
  logic [NW-1:0] num_r [NW-1];
  logic [DW-1:0] den_r [NW-1];
  logic [NW-1:0] quo_r [NW];

  generate
    for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW-1:0] ri;
      logic [NW-1:0] ni;
      logic [DW-1:0] di;
      logic [NW-1:0] qi;
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
        assign ri = '0;
        assign ni = num;
        assign di = den;
        assign qi = '0;
      end else begin : g_next
        assign ri = rem_r[s-1];
        assign ni = num_r[s-1];
        assign di = den_r[s-1];
        assign qi = quo_r[s-1];
      end

      assign t    = {ri, ni[NW-1]};
      assign ge   = (t >= {1'b0, di});
      assign diff = t - {1'b0, di};

      always_ff @(posedge clk) begin
        if (en) begin
          quo_r[s] <= {qi[NW-2:0], ge};
        end
      end

      if (s < NW - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s] <= ge ? diff[DW-1:0] : t[DW-1:0];
            num_r[s] <= ni << 1;
            den_r[s] <= di;
          end
        end
      end
    end
  endgenerate

  assign quo = quo_r[NW-1];
endmodule

// File: design/pcs_log2.sv
// Pipelined base-2 logarithm in Q16, one fraction bit per squaring stage.
module pcs_log2 #(
  parameter int VW = 36
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [VW-1:0]           v,
  output logic [$clog2(VW)+15:0]  lg
);
  import pcs_pkg::*;

  localparam int PW = $clog2(VW);
  localparam int FB = LOG_FRAC_BITS;

  logic [PW-1:0]         p_r [FB+1];
  logic [FB-1:0]         f_r [FB+1];
  logic [LOG_MANT_W-1:0] m_r [FB];

  logic [PW-1:0]         p0;
  logic [VW+LOG_Q-1:0]   sh;

  always_comb begin
    p0 = '0;
    for (int i = 0; i < VW; i++) begin
      if (v[i]) begin
        p0 = PW'(i);
      end
    end
  end

  assign sh = {v, {LOG_Q{1'b0}}} >> p0;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= p0;
      m_r[0] <= sh[LOG_MANT_W-1:0];
      f_r[0] <= '0;
    end
  end

  generate
    for (genvar s = 0; s < FB; s++) begin : g_sq
      logic [2*LOG_MANT_W-1:0] sq;
      logic [LOG_MANT_W:0]     t;
      assign sq = m_r[s] * m_r[s];
      assign t  = sq[2*LOG_MANT_W-1:LOG_Q];

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[s+1] <= p_r[s];
          f_r[s+1] <= f_r[s] | ({{(FB-1){1'b0}}, t[LOG_MANT_W]} << (FB - 1 - s));
        end
      end

      if (s < FB - 1) begin : g_m
        always_ff @(posedge clk) begin
          if (en) begin
            m_r[s+1] <= t[LOG_MANT_W] ? t[LOG_MANT_W:1] : t[LOG_MANT_W-1:0];
          end
        end
      end
    end
  endgenerate

  assign lg = {p_r[FB], f_r[FB]};
endmodule

// File: design/pcs_exp2.sv
// Pipelined 2^(g/65536) in Q30 by a chain of constant square roots.
module pcs_exp2 (
  input  logic          clk,
  input  logic          en,
  input  logic [15:0]   g,
  output logic [30:0]   q
);
  import pcs_pkg::*;

  logic [30:0] q_r [EXP_BITS];
  logic [15:0] g_r [EXP_BITS-1];

  generate
    for (genvar s = 0; s < EXP_BITS; s++) begin : g_stage
      localparam logic [30:0] ROOT = exp_root(s);
      logic [30:0] qi;
      logic [15:0] gi;
      logic [61:0] prod;

      if (s == 0) begin : g_first
        assign qi = 31'h4000_0000;
        assign gi = g;
      end else begin : g_next
        assign qi = q_r[s-1];
        assign gi = g_r[s-1];
      end

      assign prod = qi * ROOT;

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[s] <= gi[EXP_BITS-1-s] ? prod[60:30] : qi;
        end
      end

      if (s < EXP_BITS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            g_r[s] <= gi;
          end
        end
      end
    end
  endgenerate

  assign q = q_r[EXP_BITS-1];
endmodule

// File: design/pose_confidence_score_top.sv
// Top level of the pose confidence scoring pipeline.
// Usage:
//   in_ch   takes one pose-fit report per cycle while ready (valid/ready).
//   out_ch  gives one Q1.15 confidence item per report, in order.
//   cfg_ch  writes sigma_px (0), kappa_good (1), kappa_bad (2); always ready.
//           Write only while no item is in flight.
// Throughput: one item per cycle while the output buffer is not full; the
//   pipeline depth is set by the 48-stage one-bit-per-stage divider of the
//   reprojection ratio, with two 17-stage logarithm chains beside it, then
//   three summing stages and a 16-stage exponent chain after it.
// Reset: registers return to sigma 2.0 px, kappa_good 100, kappa_bad 10000;
//   the pipeline and output buffer empty.
// Stall: a two-entry output buffer takes results; while one result waits
//   the pipeline keeps accepting. When both entries are full the whole
//   pipeline holds and in_ch.ready drops until out_ch.ready returns.
module pose_confidence_score_top #(
  parameter int MAX_POINTS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  pcs_in_if.sink     in_ch,
  pcs_out_if.source  out_ch,
  pcs_cfg_if.sink    cfg_ch
);
  import pcs_pkg::*;

  localparam logic [7:0] CNT_LIM = (MAX_POINTS > 255) ? 8'd255 : 8'(MAX_POINTS);
  localparam int L1W     = $clog2(LOG1_VW) + 16;
  localparam int L2W     = $clog2(LOG2_VW) + 16;
  localparam int LOG_LAT = LOG_FRAC_BITS + 1;
  localparam int IDX_A   = 1;
  localparam int IDX_D   = IDX_A + DIV_NW + 1;
  localparam int IDX_B   = IDX_A + LOG_LAT + 1;
  localparam int IDX_C   = IDX_B + LOG_LAT + 1;
  localparam int IDX_J   = (IDX_D > IDX_C) ? IDX_D : IDX_C;
  localparam int DLY_D   = IDX_J - IDX_D;
  localparam int DLY_C   = IDX_J - IDX_C;
  localparam int IDX_G   = IDX_J + 3;
  localparam int LAST    = IDX_G + EXP_BITS;

  // configuration
  logic [15:0] sigma_r;
  logic [31:0] kappa_good_r;
  logic [31:0] kappa_bad_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r      <= SIGMA_RST;
      kappa_good_r <= KAPPA_GOOD_RST;
      kappa_bad_r  <= KAPPA_BAD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SIGMA_PX:   sigma_r      <= cfg_ch.data[15:0];
        CFG_KAPPA_GOOD: kappa_good_r <= cfg_ch.data;
        CFG_KAPPA_BAD:  kappa_bad_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // flow control
  logic [LAST:1]  vld_r;
  logic [1:0]     cnt_r;
  logic           wp_r;
  logic           rp_r;
  logic [15:0]    mem_r [2];
  logic           en;
  logic           push;
  logic           pop;
  logic [15:0]    conf_nxt;

  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;
  assign push        = en && vld_r[LAST];
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:1], in_ch.valid};
    end
  end

  // stage A
  logic [31:0] k_c;
  logic [31:0] kg1;
  logic        c_one;
  logic        c_zero;
  logic [7:0]  inl_c;
  logic [7:0]  pts_c;
  logic [31:0] cdiff;
  logic [35:0] d10_c;
  logic        cost_up;
  pcs_fa_t     fa_nxt;

  logic [31:0] ee_r;
  logic [31:0] ss_r;
  logic [31:0] k_r;
  logic [7:0]  inl_r;
  logic [7:0]  pts_r;
  logic [31:0] cp_r;
  logic [35:0] d10_r;
  pcs_fa_t     fa_r;

  always_comb begin
    k_c     = (in_ch.cond_number == '0) ? COND_DEFAULT : in_ch.cond_number;
    c_one   = (k_c <= kappa_good_r);
    c_zero  = !c_one && (k_c >= kappa_bad_r);
    inl_c   = (in_ch.inlier_count > CNT_LIM) ? CNT_LIM : in_ch.inlier_count;
    pts_c   = (in_ch.point_count > CNT_LIM) ? CNT_LIM : in_ch.point_count;
    cdiff   = in_ch.cost_prior - in_ch.cost_final;
    d10_c   = ({4'b0, cdiff} << 3) + ({4'b0, cdiff} << 1);
    cost_up = (in_ch.cost_prior != '0) && (in_ch.cost_final >= in_ch.cost_prior);
    fa_nxt.e_nz     = (in_ch.reproj_error != '0);
    fa_nxt.c_active = !c_one && !c_zero;
    fa_nxt.m_use    = (in_ch.cost_prior != '0) && !cost_up &&
                      (d10_c < {4'b0, in_ch.cost_prior});
    fa_nxt.zero     = ((in_ch.reproj_error != '0) && (sigma_r == '0)) || c_zero ||
                      (inl_c == '0) || (pts_c == '0) || cost_up;
  end

  assign kg1 = (kappa_good_r == '0) ? 32'd1 : kappa_good_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ee_r  <= {16'b0, in_ch.reproj_error} * {16'b0, in_ch.reproj_error};
      ss_r  <= {16'b0, sigma_r} * {16'b0, sigma_r};
      k_r   <= k_c;
      inl_r <= inl_c;
      pts_r <= pts_c;
      cp_r  <= in_ch.cost_prior;
      d10_r <= d10_c;
      fa_r  <= fa_nxt;
    end
  end

  // reprojection branch
  logic [DIV_NW-1:0] quo;
  logic [32:0]       x_c;
  logic [48:0]       lrp;
  logic [31:0]       lr_r;
  logic [31:0]       lr_j;

  pcs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk (clk),
    .en  (en),
    .num ({ee_r, 16'b0}),
    .den (ss_r),
    .quo (quo)
  );

  assign x_c = (quo > 48'h1_0000_0000) ? 33'h1_0000_0000 : quo[32:0];
  assign lrp = {16'b0, x_c} * 49'(HALF_LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (en) begin
      lr_r <= lrp[47:16];
    end
  end

  pcs_delay #(.W(32), .D(DLY_D)) u_dly_lr (
    .clk (clk), .en (en), .d (lr_r), .q (lr_j)
  );

  // logarithm branch, first level
  logic [L1W-1:0] l_kb;
  logic [L1W-1:0] l_k;
  logic [L1W-1:0] l_kg;
  logic [L1W-1:0] l_d10;
  logic [L1W-1:0] l_cp;
  logic [L1W-1:0] l_inl;
  logic [L1W-1:0] l_pts;
  pcs_fa_t        fa_b;

  pcs_log2 #(.VW(LOG1_VW)) u_log_kb (
    .clk (clk), .en (en), .v ({4'b0, kappa_bad_r}), .lg (l_kb)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_k (
    .clk (clk), .en (en), .v ({4'b0, k_r}), .lg (l_k)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_kg (
    .clk (clk), .en (en), .v ({4'b0, kg1}), .lg (l_kg)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_d10 (
    .clk (clk), .en (en), .v (d10_r), .lg (l_d10)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_cp (
    .clk (clk), .en (en), .v ({4'b0, cp_r}), .lg (l_cp)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_inl (
    .clk (clk), .en (en), .v ({28'b0, inl_r}), .lg (l_inl)
  );
  pcs_log2 #(.VW(LOG1_VW)) u_log_pts (
    .clk (clk), .en (en), .v ({28'b0, pts_r}), .lg (l_pts)
  );

  pcs_delay #(.W($bits(pcs_fa_t)), .D(LOG_LAT)) u_dly_fa (
    .clk (clk), .en (en), .d (fa_r), .q (fa_b)
  );

  // stage B
  logic signed [LV_W-1:0] nn_c;
  logic signed [LV_W-1:0] dd_c;
  pcs_fb_t                fb_nxt;
  logic [LOG2_VW-1:0]     nn_r;
  logic [LOG2_VW-1:0]     dd_r;
  pcs_fb_t                fb_r;

  always_comb begin
    nn_c = $signed({1'b0, l_kb}) - $signed({1'b0, l_k});
    dd_c = $signed({1'b0, l_kb}) - $signed({1'b0, l_kg});
    fb_nxt.li       = $signed({1'b0, l_inl}) - $signed({1'b0, l_pts});
    fb_nxt.lm       = fa_b.m_use ? $signed({1'b0, l_d10}) - $signed({1'b0, l_cp}) : '0;
    fb_nxt.e_nz     = fa_b.e_nz;
    fb_nxt.c_active = fa_b.c_active;
    fb_nxt.zero     = fa_b.zero ||
                      (fa_b.c_active && (nn_c[LV_W-1] || (nn_c == '0) ||
                                         dd_c[LV_W-1] || (dd_c == '0)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r <= nn_c[LOG2_VW-1:0];
      dd_r <= dd_c[LOG2_VW-1:0];
      fb_r <= fb_nxt;
    end
  end

  // logarithm branch, second level and stage C
  logic [L2W-1:0] l_nn;
  logic [L2W-1:0] l_dd;
  pcs_fb_t        fb_c;
  pcs_fc_t        fc_nxt;
  pcs_fc_t        fc_r;
  pcs_fc_t        fc_j;

  pcs_log2 #(.VW(LOG2_VW)) u_log_nn (
    .clk (clk), .en (en), .v (nn_r), .lg (l_nn)
  );
  pcs_log2 #(.VW(LOG2_VW)) u_log_dd (
    .clk (clk), .en (en), .v (dd_r), .lg (l_dd)
  );

  pcs_delay #(.W($bits(pcs_fb_t)), .D(LOG_LAT)) u_dly_fb (
    .clk (clk), .en (en), .d (fb_r), .q (fb_c)
  );

  always_comb begin
    fc_nxt.lc   = fb_c.c_active ? $signed({2'b0, l_nn}) - $signed({2'b0, l_dd}) : '0;
    fc_nxt.li   = fb_c.li;
    fc_nxt.lm   = fb_c.lm;
    fc_nxt.zero = fb_c.zero;
    fc_nxt.e_nz = fb_c.e_nz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fc_r <= fc_nxt;
    end
  end

  pcs_delay #(.W($bits(pcs_fc_t)), .D(DLY_C)) u_dly_fc (
    .clk (clk), .en (en), .d (fc_r), .q (fc_j)
  );

  // weighting, sum, exponent split
  logic signed [SUM_W-1:0] lr_w;
  logic signed [SUM_W-1:0] pr_r;
  logic signed [SUM_W-1:0] pc_r;
  logic signed [SUM_W-1:0] pi_r;
  logic signed [SUM_W-1:0] pm_r;
  logic                    ze_r;
  logic signed [SUM_W-1:0] s_r;
  logic                    zf_r;
  logic [SUM_W-1:0]        mg;
  logic [17:0]             n_c;
  logic [15:0]             f_c;
  pcs_fg_t                 fg_nxt;
  pcs_fg_t                 fg_r;
  logic [15:0]             g_r;

  assign lr_w = $signed({18'b0, lr_j});

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= fc_j.e_nz ? lr_w * SUM_W'(W_R) : '0;
      pc_r <= SUM_W'(fc_j.lc) * SUM_W'(W_C);
      pi_r <= SUM_W'(fc_j.li) * SUM_W'(W_I);
      pm_r <= SUM_W'(fc_j.lm) * SUM_W'(W_M);
      ze_r <= fc_j.zero;
      s_r  <= pc_r + pi_r + pm_r - pr_r;
      zf_r <= ze_r;
    end
  end

  always_comb begin
    mg           = -s_r;
    n_c          = mg[49:32];
    f_c          = mg[31:16];
    fg_nxt.zero  = zf_r;
    fg_nxt.sat   = !s_r[SUM_W-1];
    fg_nxt.big   = (n_c > 18'd16);
    fg_nxt.gfull = (f_c == '0);
    fg_nxt.n     = n_c[4:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fg_r <= fg_nxt;
      g_r  <= 16'(17'h1_0000 - {1'b0, f_c});
    end
  end

  // exponent and final rounding
  logic [30:0] q_x;
  pcs_fg_t     fg_x;
  logic [31:0] q_eff;
  logic [47:0] rsum;
  logic [47:0] rshift;

  pcs_exp2 u_exp (
    .clk (clk), .en (en), .g (g_r), .q (q_x)
  );

  pcs_delay #(.W($bits(pcs_fg_t)), .D(EXP_BITS)) u_dly_fg (
    .clk (clk), .en (en), .d (fg_r), .q (fg_x)
  );

  always_comb begin
    q_eff  = fg_x.gfull ? 32'h8000_0000 : {1'b0, q_x};
    rsum   = {1'b0, q_eff, 15'b0} + (48'd1 << (6'(fg_x.n) + 6'd30));
    rshift = rsum >> (6'(fg_x.n) + 6'd31);
    priority if (fg_x.zero) begin
      conf_nxt = '0;
    end else if (fg_x.sat) begin
      conf_nxt = CONF_ONE;
    end else if (fg_x.big) begin
      conf_nxt = '0;
    end else begin
      conf_nxt = rshift[15:0];
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= conf_nxt;
    end
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.confidence = mem_r[rp_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.confidence <= CONF_ONE))
    else $error("confidence above one");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while held");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("buffer count not decremented on pop");

endmodule
